// ----- hw/rtl/lobm_pkg.sv -----
// Shared types, codes and defaults for the limit order book matcher.
// Used by every module of the block; depends on nothing.
package lobm_pkg;

    // Default number of resting entries in the book.
    localparam int BOOK_CAPACITY_DEF = 64;

    // Depth of the request queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Completion status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_BOOK_FULL = 3'd4;

    // Result kinds.
    localparam logic KIND_TRADE      = 1'b0;
    localparam logic KIND_COMPLETION = 1'b1;

    // Request type codes.
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_CANCEL = 1'b1;

    // Order type codes.
    localparam logic ORD_LIMIT  = 1'b0;
    localparam logic ORD_MARKET = 1'b1;

    // Side codes.
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Classified request as it travels from the front to the back.
    typedef struct packed {
        logic        is_cancel;
        logic [31:0] id;
        logic        sell;
        logic        market;
        logic [15:0] price;
        logic [23:0] qty;
        logic [15:0] sym;
        logic [31:0] ts;
    } req_t;

    // One resting entry of the book.
    typedef struct packed {
        logic [31:0] id;
        logic        sell;
        logic [15:0] price;
        logic [23:0] remaining;
        logic [31:0] arrival;
    } entry_t;

    // One result item.
    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [31:0] buyer_id;
        logic [31:0] seller_id;
        logic [15:0] symbol;
        logic [15:0] price;
        logic [23:0] quantity;
        logic [31:0] time_stamp;
        logic        last;
        logic [15:0] bid_price;
        logic [15:0] ask_price;
        logic [1:0]  best_valid;
    } result_t;

    // Sequencer states of the matching engine.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FILL,
        S_FINAL
    } state_t;

endpackage

// ----- hw/rtl/lobm_front.sv -----
// Front stage: accepts request items, classifies them and hands them on.
// Depends on lobm_pkg.
module lobm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic             req_type,
    input  logic [31:0]      req_id,
    input  logic             side,
    input  logic             order_type,
    input  logic [15:0]      price,
    input  logic [23:0]      quantity,
    input  logic [15:0]      symbol_code,
    input  logic [31:0]      timestamp,
    output logic             push_valid,
    input  logic             push_ready,
    output lobm_pkg::req_t   push_item
);

    logic           slot_valid_reg;
    lobm_pkg::req_t slot_reg;
    lobm_pkg::req_t slot_next;
    logic           take;

    // The holding slot frees as soon as the queue takes its item.
    assign req_ready  = !slot_valid_reg || push_ready;
    assign take       = req_valid && req_ready;
    assign push_valid = slot_valid_reg;
    assign push_item  = slot_reg;

    // Classify the incoming request.
    always_comb
    begin
        slot_next.is_cancel = (req_type == lobm_pkg::REQ_CANCEL);
        slot_next.id        = req_id;
        slot_next.sell      = (side == lobm_pkg::SIDE_SELL);
        slot_next.market    = (order_type == lobm_pkg::ORD_MARKET);
        slot_next.price     = price;
        slot_next.qty       = quantity;
        slot_next.sym       = symbol_code;
        slot_next.ts        = timestamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            slot_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            slot_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

// ----- hw/rtl/lobm_queue.sv -----
// Short request queue between the front and the matching engine.
// Depends on lobm_pkg.
module lobm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  lobm_pkg::req_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output lobm_pkg::req_t pop_item
);

    localparam int CNT_W = $clog2(lobm_pkg::QUEUE_DEPTH + 1);
    localparam int PW    = lobm_pkg::QUEUE_PTR_W;

    lobm_pkg::req_t                   slots_reg [lobm_pkg::QUEUE_DEPTH];
    logic [lobm_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [lobm_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != CNT_W'(lobm_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers wrap at the queue depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(lobm_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(lobm_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/lobm_engine.sv -----
// Matching engine: book storage, sequential scans, fills and result output.
// Depends on lobm_pkg.
module lobm_engine #(
    parameter int BOOK_CAPACITY = lobm_pkg::BOOK_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  lobm_pkg::req_t    q_item,
    output logic              res_valid,
    input  logic              res_ready,
    output lobm_pkg::result_t res
);

    localparam int IW = $clog2(BOOK_CAPACITY);
    localparam int CW = $clog2(BOOK_CAPACITY + 1);

    // Book storage: field memory plus one valid flop per entry.
    lobm_pkg::entry_t mem [BOOK_CAPACITY];
    logic [BOOK_CAPACITY-1:0] valid_reg;

    lobm_pkg::state_t  state_reg, state_next;
    lobm_pkg::req_t    req_reg;
    logic [23:0]       qty_reg;
    logic [CW-1:0]     nfill_reg;
    lobm_pkg::result_t pend_reg;
    logic              have_pend_reg;
    logic [2:0]        status_reg;
    logic [31:0]       arr_cnt_reg;

    // Scan pipeline.
    logic [CW-1:0]     scan_cnt_reg;
    logic              rd_pend_reg;
    logic [IW-1:0]     rd_idx_reg;
    lobm_pkg::entry_t  rd_data_reg;

    // Scan trackers.
    logic              dup_reg;
    logic              ob_v_reg;
    logic [IW-1:0]     ob_idx_reg;
    lobm_pkg::entry_t  ob_reg;
    logic [31:0]       ob_age_reg;
    logic              own_v_reg;
    logic [15:0]       own_p_reg;
    logic              free_v_reg;
    logic [IW-1:0]     free_idx_reg;

    lobm_pkg::result_t out_reg;
    logic              out_valid_reg;

    // Control.
    logic              out_free;
    logic              start_scan;
    logic              scan_done;
    logic              can_fill;
    logic              do_rest;
    logic              fill_go;
    logic              emit_mid;
    logic              emit_final;
    logic [2:0]        status_next;

    // Per-entry scan evaluation.
    logic              e_valid;
    logic              e_match;
    logic              e_cancel_hit;
    logic [31:0]       e_age;
    logic              e_opp_better;
    logic              e_own_better;
    logic [23:0]       fill_qty;
    lobm_pkg::result_t final_res;
    logic [15:0]       bid_p;
    logic [15:0]       ask_p;
    logic              bid_v;
    logic              ask_v;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign scan_done = (scan_cnt_reg == CW'(BOOK_CAPACITY)) && !rd_pend_reg;
    assign fill_qty  = (qty_reg < ob_reg.remaining) ? qty_reg : ob_reg.remaining;

    // Whether the best opposite entry can trade with the incoming order.
    always_comb
    begin
        can_fill = !req_reg.is_cancel && !dup_reg && (qty_reg != '0)
                   && (nfill_reg != CW'(BOOK_CAPACITY)) && ob_v_reg
                   && (req_reg.market
                       || (req_reg.sell ? (ob_reg.price >= req_reg.price)
                                        : (ob_reg.price <= req_reg.price)));
        do_rest  = !req_reg.is_cancel && !dup_reg && (qty_reg != '0)
                   && !req_reg.market && free_v_reg;
    end

    // Status of the request once no further fill is possible.
    always_comb
    begin
        priority if (req_reg.is_cancel)
        begin
            status_next = dup_reg ? lobm_pkg::ST_CANCELLED : lobm_pkg::ST_NOT_FOUND;
        end
        else if (dup_reg)
        begin
            status_next = lobm_pkg::ST_DUPLICATE;
        end
        else if ((qty_reg != '0) && !req_reg.market && !free_v_reg)
        begin
            status_next = lobm_pkg::ST_BOOK_FULL;
        end
        else
        begin
            status_next = lobm_pkg::ST_OK;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lobm_pkg::S_IDLE:   if (q_valid) state_next = lobm_pkg::S_SCAN;
            lobm_pkg::S_SCAN:   if (scan_done) state_next = lobm_pkg::S_DECIDE;
            lobm_pkg::S_DECIDE: state_next = can_fill ? lobm_pkg::S_FILL : lobm_pkg::S_FINAL;
            lobm_pkg::S_FILL:   if (!have_pend_reg || out_free) state_next = lobm_pkg::S_SCAN;
            lobm_pkg::S_FINAL:  if (out_free) state_next = lobm_pkg::S_IDLE;
            default:            state_next = lobm_pkg::S_IDLE;
        endcase
    end

    // Control outputs of each state.
    always_comb
    begin
        q_pop      = 1'b0;
        start_scan = 1'b0;
        fill_go    = 1'b0;
        emit_mid   = 1'b0;
        emit_final = 1'b0;
        unique case (state_reg)
            lobm_pkg::S_IDLE:
            begin
                q_pop      = q_valid;
                start_scan = q_valid;
            end
            lobm_pkg::S_FILL:
            begin
                fill_go    = !have_pend_reg || out_free;
                emit_mid   = have_pend_reg && out_free;
                start_scan = fill_go;
            end
            lobm_pkg::S_FINAL:
            begin
                emit_final = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Evaluate the entry whose data the memory returned this cycle.
    always_comb
    begin
        e_valid      = rd_pend_reg && valid_reg[rd_idx_reg];
        e_match      = (rd_data_reg.id == req_reg.id);
        e_cancel_hit = e_valid && e_match && req_reg.is_cancel;
        e_age        = arr_cnt_reg - rd_data_reg.arrival;
        e_opp_better = !ob_v_reg
                       || (req_reg.sell ? (rd_data_reg.price > ob_reg.price)
                                        : (rd_data_reg.price < ob_reg.price))
                       || ((rd_data_reg.price == ob_reg.price) && (e_age > ob_age_reg));
        e_own_better = !own_v_reg
                       || (req_reg.sell ? (rd_data_reg.price < own_p_reg)
                                        : (rd_data_reg.price > own_p_reg));
    end

    // Final result: the held trade or a completion report, with book tops.
    always_comb
    begin
        bid_v = req_reg.sell ? ob_v_reg : own_v_reg;
        ask_v = req_reg.sell ? own_v_reg : ob_v_reg;
        bid_p = req_reg.sell ? ob_reg.price : own_p_reg;
        ask_p = req_reg.sell ? own_p_reg : ob_reg.price;
        if (have_pend_reg)
        begin
            final_res = pend_reg;
        end
        else
        begin
            final_res      = '0;
            final_res.kind = lobm_pkg::KIND_COMPLETION;
        end
        final_res.status     = status_reg;
        final_res.last       = 1'b1;
        final_res.bid_price  = bid_v ? bid_p : '0;
        final_res.ask_price  = ask_v ? ask_p : '0;
        final_res.best_valid = {ask_v, bid_v};
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lobm_pkg::S_IDLE;
            valid_reg     <= '0;
            arr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            have_pend_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            scan_cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Scan address counter.
            if (start_scan)
            begin
                scan_cnt_reg <= '0;
                rd_pend_reg  <= 1'b0;
            end
            else if (state_reg == lobm_pkg::S_SCAN)
            begin
                rd_pend_reg <= (scan_cnt_reg != CW'(BOOK_CAPACITY));
                if (scan_cnt_reg != CW'(BOOK_CAPACITY))
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end

            // Entry valid bits.
            if (e_cancel_hit)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
            end
            if (fill_go && (ob_reg.remaining == fill_qty))
            begin
                valid_reg[ob_idx_reg] <= 1'b0;
            end
            if ((state_reg == lobm_pkg::S_DECIDE) && !can_fill && do_rest)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                arr_cnt_reg             <= arr_cnt_reg + 1'b1;
            end

            // Held trade.
            if (q_pop)
            begin
                have_pend_reg <= 1'b0;
            end
            else if (fill_go)
            begin
                have_pend_reg <= 1'b1;
            end

            // Output register.
            if (emit_mid || emit_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Book memory: one read port for the scan, one write port.
    always_ff @(posedge clk)
    begin
        if (state_reg == lobm_pkg::S_SCAN)
        begin
            rd_data_reg <= mem[scan_cnt_reg[IW-1:0]];
            rd_idx_reg  <= scan_cnt_reg[IW-1:0];
        end
        if (fill_go)
        begin
            mem[ob_idx_reg] <= '{id: ob_reg.id, sell: ob_reg.sell, price: ob_reg.price,
                                 remaining: ob_reg.remaining - fill_qty,
                                 arrival: ob_reg.arrival};
        end
        else if ((state_reg == lobm_pkg::S_DECIDE) && !can_fill && do_rest)
        begin
            mem[free_idx_reg] <= '{id: req_reg.id, sell: req_reg.sell, price: req_reg.price,
                                   remaining: qty_reg, arrival: arr_cnt_reg};
        end
    end

    // Request, scan trackers and result payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_reg   <= q_item;
            qty_reg   <= q_item.qty;
            nfill_reg <= '0;
            dup_reg   <= 1'b0;
        end

        // Trackers restart with every scan; the duplicate flag spans the request.
        if (start_scan)
        begin
            ob_v_reg   <= 1'b0;
            own_v_reg  <= 1'b0;
            free_v_reg <= 1'b0;
        end
        else if (rd_pend_reg)
        begin
            if (e_valid && e_match)
            begin
                dup_reg <= 1'b1;
            end
            if (e_valid && !e_cancel_hit)
            begin
                if (rd_data_reg.sell != req_reg.sell)
                begin
                    if (e_opp_better)
                    begin
                        ob_v_reg   <= 1'b1;
                        ob_idx_reg <= rd_idx_reg;
                        ob_reg     <= rd_data_reg;
                        ob_age_reg <= e_age;
                    end
                end
                else if (e_own_better)
                begin
                    own_v_reg <= 1'b1;
                    own_p_reg <= rd_data_reg.price;
                end
            end
            if (!valid_reg[rd_idx_reg] && !free_v_reg)
            begin
                free_v_reg   <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
        end

        // Closing decision and resting the remainder.
        if ((state_reg == lobm_pkg::S_DECIDE) && !can_fill)
        begin
            status_reg <= status_next;
            if (do_rest
                && (!own_v_reg
                    || (req_reg.sell ? (req_reg.price < own_p_reg)
                                     : (req_reg.price > own_p_reg))))
            begin
                own_v_reg <= 1'b1;
                own_p_reg <= req_reg.price;
            end
        end

        // A fill builds the next trade report and hands out the previous one.
        if (fill_go)
        begin
            pend_reg  <= '{kind:       lobm_pkg::KIND_TRADE,
                           buyer_id:   req_reg.sell ? ob_reg.id : req_reg.id,
                           seller_id:  req_reg.sell ? req_reg.id : ob_reg.id,
                           symbol:     req_reg.sym,
                           price:      ob_reg.price,
                           quantity:   fill_qty,
                           time_stamp: req_reg.ts,
                           default:    '0};
            qty_reg   <= qty_reg - fill_qty;
            nfill_reg <= nfill_reg + 1'b1;
        end

        if (emit_mid)
        begin
            out_reg <= pend_reg;
        end
        else if (emit_final)
        begin
            out_reg <= final_res;
        end
    end

endmodule

// ----- hw/rtl/limit_order_book_matcher_core.sv -----
// Top level of the limit order book matcher: front, queue and engine.
// Depends on lobm_pkg, lobm_front, lobm_queue and lobm_engine.
//
//   Channel   Handshake              Moves
//   request   req_valid / req_ready  one add or cancel item
//   result    res_valid / res_ready  one trade or completion item
//
// Each book scan reads one entry per cycle, then judges the last entry and
// closes the scan. A request leaves the queue in the idle state; each scan
// is then followed by a decide state and a fill or final state, and a fill
// starts a new scan. Reset clears the book at once through the entry valid flops.
// The engine waits while the result register is full and it has a result to hand
// over; the queue keeps accepting requests until it and the front slot are full.
module limit_order_book_matcher_core #(
    parameter int BOOK_CAPACITY = lobm_pkg::BOOK_CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        req_type,
    input  logic [31:0] req_id,
    input  logic        side,
    input  logic        order_type,
    input  logic [15:0] price,
    input  logic [23:0] quantity,
    input  logic [15:0] symbol_code,
    input  logic [31:0] timestamp,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        result_kind,
    output logic [2:0]  status,
    output logic [31:0] buyer_id,
    output logic [31:0] seller_id,
    output logic [15:0] trade_symbol,
    output logic [15:0] trade_price,
    output logic [23:0] trade_quantity,
    output logic [31:0] trade_time,
    output logic        last,
    output logic [15:0] best_bid_price,
    output logic [15:0] best_ask_price,
    output logic [1:0]  best_valid
);

    logic              push_valid;
    logic              push_ready;
    lobm_pkg::req_t    push_item;
    logic              pop_valid;
    logic              pop_ready;
    lobm_pkg::req_t    pop_item;
    lobm_pkg::result_t res;

    lobm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .req_id      (req_id),
        .side        (side),
        .order_type  (order_type),
        .price       (price),
        .quantity    (quantity),
        .symbol_code (symbol_code),
        .timestamp   (timestamp),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    lobm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    lobm_engine #(
        .BOOK_CAPACITY (BOOK_CAPACITY)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_pop     (pop_ready),
        .q_item    (pop_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Result fields onto their ports.
    assign result_kind    = res.kind;
    assign status         = res.status;
    assign buyer_id       = res.buyer_id;
    assign seller_id      = res.seller_id;
    assign trade_symbol   = res.symbol;
    assign trade_price    = res.price;
    assign trade_quantity = res.quantity;
    assign trade_time     = res.time_stamp;
    assign last           = res.last;
    assign best_bid_price = res.bid_price;
    assign best_ask_price = res.ask_price;
    assign best_valid     = res.best_valid;

endmodule

// ----- hw/rtl/lobm_checker.sv -----
// Port-level checks of the matcher's result stream, bound to the top level.
// Depends on lobm_pkg and limit_order_book_matcher_core.
module lobm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        result_kind,
    input logic [2:0]  status,
    input logic [23:0] trade_quantity,
    input logic        last,
    input logic [1:0]  best_valid
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_kind) && $stable(last)
                                    && $stable(trade_quantity))
        else $error("stalled result changed");

    // A completion report always closes its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (result_kind == lobm_pkg::KIND_COMPLETION) |-> last)
        else $error("completion report without last");

    // Intermediate results carry no status and no book tops.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> (status == lobm_pkg::ST_OK) && (best_valid == 2'b00))
        else $error("intermediate result carries status");

    // A trade always moves some quantity.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (result_kind == lobm_pkg::KIND_TRADE) |-> (trade_quantity != '0))
        else $error("trade of zero quantity");

endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .result_kind    (result_kind),
    .status         (status),
    .trade_quantity (trade_quantity),
    .last           (last),
    .best_valid     (best_valid)
);

// ----- verif/tb.sv -----
// Self-checking testbench for limit_order_book_matcher_core.
// Depends on lobm_pkg; predicts every trade and completion item from its own
// copy of the book and checks each item the block returns, in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = lobm_pkg::BOOK_CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int SETTLE_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic        req_type;
    logic [31:0] req_id;
    logic        side;
    logic        order_type;
    logic [15:0] price;
    logic [23:0] quantity;
    logic [15:0] symbol_code;
    logic [31:0] timestamp;
    logic        res_valid;
    logic        res_ready;
    logic        result_kind;
    logic [2:0]  status;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [15:0] trade_symbol;
    logic [15:0] trade_price;
    logic [23:0] trade_quantity;
    logic [31:0] trade_time;
    logic        last;
    logic [15:0] best_bid_price;
    logic [15:0] best_ask_price;
    logic [1:0]  best_valid;

    // Model of the book as the block should hold it.
    logic        bk_valid [CAP];
    logic [31:0] bk_id [CAP];
    logic        bk_sell [CAP];
    logic [15:0] bk_price [CAP];
    logic [23:0] bk_qty [CAP];
    logic [31:0] bk_arrival [CAP];
    logic [31:0] arrival_cnt;

    lobm_pkg::result_t pending_reports[$];
    int          mismatch_count;
    int          cycle_count;
    int          stall_request;
    bit          sender_idles;
    bit          receiver_idles;

    limit_order_book_matcher_core DUT (.*);

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Receiver: random stalls, a few long ones, plus a long hold-off on request.
    always @(posedge clk)
    begin
        int hold_left;
        if (stall_request > 0)
        begin
            hold_left = stall_request;
            stall_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else if (!receiver_idles)
            res_ready <= 1'b1;
        else if ($urandom_range(0, 99) < 2)
        begin
            hold_left = $urandom_range(10, 40);
            res_ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) < 7)
            res_ready <= 1'b1;
        else
            res_ready <= 1'b0;
    end

    // Result checker: each accepted item against the oldest expectation.
    always @(posedge clk)
    begin
        lobm_pkg::result_t got;
        lobm_pkg::result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            got = '{result_kind, status, buyer_id, seller_id, trade_symbol, trade_price,
                    trade_quantity, trade_time, last, best_bid_price, best_ask_price,
                    best_valid};
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item: %p", got);
            end
            else
            begin
                want = pending_reports[0];
                pending_reports.delete(0);
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    // Best resting entry on one side: highest bid or lowest ask, oldest first.
    function automatic int find_best(logic sell_side);
        int best;
        logic better;
        best = -1;
        for (int i = 0; i < CAP; i++)
        begin
            if (!bk_valid[i] || bk_sell[i] != sell_side)
                continue;
            if (best < 0)
                best = i;
            else
            begin
                better = sell_side ? (bk_price[i] < bk_price[best])
                                   : (bk_price[i] > bk_price[best]);
                if (!better && bk_price[i] == bk_price[best])
                    better = (arrival_cnt - bk_arrival[i]) > (arrival_cnt - bk_arrival[best]);
                if (better)
                    best = i;
            end
        end
        return best;
    endfunction

    // Apply one request to the model book and queue the items it must produce.
    function automatic void match_request(lobm_pkg::req_t r);
        lobm_pkg::result_t batch[$];
        lobm_pkg::result_t res;
        logic [2:0] st;
        logic [23:0] left;
        logic [23:0] fill;
        int b;
        int slot;
        logic dup;
        st = lobm_pkg::ST_OK;
        left = r.qty;
        if (r.is_cancel)
        begin
            st = lobm_pkg::ST_NOT_FOUND;
            for (int i = 0; i < CAP; i++)
                if (bk_valid[i] && bk_id[i] == r.id)
                begin
                    bk_valid[i] = 1'b0;
                    st = lobm_pkg::ST_CANCELLED;
                end
        end
        else
        begin
            dup = 1'b0;
            for (int i = 0; i < CAP; i++)
                if (bk_valid[i] && bk_id[i] == r.id)
                    dup = 1'b1;
            if (dup)
                st = lobm_pkg::ST_DUPLICATE;
            else
            begin
                // Sweep the opposite side at the resting prices.
                while (left > 0 && batch.size() < CAP)
                begin
                    b = find_best(!r.sell);
                    if (b < 0)
                        break;
                    if (!r.market && !r.sell && bk_price[b] > r.price)
                        break;
                    if (!r.market && r.sell && bk_price[b] < r.price)
                        break;
                    fill = (left < bk_qty[b]) ? left : bk_qty[b];
                    res = '0;
                    res.kind = lobm_pkg::KIND_TRADE;
                    res.buyer_id = r.sell ? bk_id[b] : r.id;
                    res.seller_id = r.sell ? r.id : bk_id[b];
                    res.symbol = r.sym;
                    res.price = bk_price[b];
                    res.quantity = fill;
                    res.time_stamp = r.ts;
                    batch = {batch, res};
                    left -= fill;
                    bk_qty[b] -= fill;
                    if (bk_qty[b] == 0)
                        bk_valid[b] = 1'b0;
                end
                // A limit remainder rests in the first free entry.
                if (left > 0 && !r.market)
                begin
                    slot = -1;
                    for (int i = 0; i < CAP; i++)
                        if (!bk_valid[i] && slot < 0)
                            slot = i;
                    if (slot < 0)
                        st = lobm_pkg::ST_BOOK_FULL;
                    else
                    begin
                        bk_valid[slot] = 1'b1;
                        bk_id[slot] = r.id;
                        bk_sell[slot] = r.sell;
                        bk_price[slot] = r.price;
                        bk_qty[slot] = left;
                        bk_arrival[slot] = arrival_cnt;
                        arrival_cnt++;
                    end
                end
            end
        end
        if (batch.size() == 0)
        begin
            res = '0;
            res.kind = lobm_pkg::KIND_COMPLETION;
            batch = {batch, res};
        end
        // The final item carries status and the top of the book.
        res = batch[batch.size() - 1];
        res.status = st;
        res.last = 1'b1;
        b = find_best(lobm_pkg::SIDE_BUY);
        if (b >= 0)
        begin
            res.bid_price = bk_price[b];
            res.best_valid[0] = 1'b1;
        end
        b = find_best(lobm_pkg::SIDE_SELL);
        if (b >= 0)
        begin
            res.ask_price = bk_price[b];
            res.best_valid[1] = 1'b1;
        end
        batch[batch.size() - 1] = res;
        foreach (batch[k])
            pending_reports = {pending_reports, batch[k]};
    endfunction

    // Offer one request item and wait until it is accepted.
    task automatic send_item(lobm_pkg::req_t r);
        int gap;
        gap = 0;
        if (sender_idles)
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= r.is_cancel;
        req_id <= r.id;
        side <= r.sell;
        order_type <= r.market;
        price <= r.price;
        quantity <= r.qty;
        symbol_code <= r.sym;
        timestamp <= r.ts;
        do
            @(posedge clk);
        while (!req_ready);
        match_request(r);
    endtask

    task automatic send_order(logic sell, logic market, logic [31:0] id,
                              logic [15:0] px, logic [23:0] q);
        send_item('{lobm_pkg::REQ_ADD, id, sell, market, px, q, 16'($urandom), $urandom});
    endtask

    task automatic send_cancel(logic [31:0] id);
        send_item('{lobm_pkg::REQ_CANCEL, id, 1'($urandom), 1'($urandom), 16'($urandom),
                    24'($urandom), 16'($urandom), $urandom});
    endtask

    // Hold the request side until every expected item has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Cancel everything the model still holds.
    task automatic clear_book();
        for (int i = 0; i < CAP; i++)
            if (bk_valid[i])
                send_cancel(bk_id[i]);
    endtask

    // Directed requests: each special case of matching.
    task automatic test_directed();
        send_cancel(32'd77);                          // cancel on an empty book
        send_order(lobm_pkg::SIDE_SELL, lobm_pkg::ORD_MARKET, 32'd1, 16'd0, 24'd5);
        send_order(lobm_pkg::SIDE_BUY, lobm_pkg::ORD_LIMIT, 32'd10, 16'd100, 24'd10);
        send_order(lobm_pkg::SIDE_BUY, lobm_pkg::ORD_LIMIT, 32'd10, 16'd100, 24'd10);
        send_order(lobm_pkg::SIDE_SELL, lobm_pkg::ORD_LIMIT, 32'd20, 16'd105, 24'd7);
        send_order(lobm_pkg::SIDE_SELL, lobm_pkg::ORD_LIMIT, 32'd21, 16'd105, 24'd7);
        send_order(lobm_pkg::SIDE_SELL, lobm_pkg::ORD_LIMIT, 32'd22, 16'd103, 24'd3);
        // Sweeps the best price, then the next price, oldest order first.
        send_order(lobm_pkg::SIDE_BUY, lobm_pkg::ORD_LIMIT, 32'd11, 16'd105, 24'd12);
        // Trades at the resting bid price.
        send_order(lobm_pkg::SIDE_SELL, lobm_pkg::ORD_LIMIT, 32'd23, 16'd90, 24'd4);
        // The market remainder is dropped.
        send_order(lobm_pkg::SIDE_BUY, lobm_pkg::ORD_MARKET, 32'd12, 16'd0, 24'd50);
        send_order(lobm_pkg::SIDE_BUY, lobm_pkg::ORD_LIMIT, 32'd13, 16'd0, 24'd0);
        send_order(lobm_pkg::SIDE_BUY, lobm_pkg::ORD_LIMIT, 32'hFFFF_FFFF, 16'd0,
                   24'hFF_FFFF);
        send_order(lobm_pkg::SIDE_SELL, lobm_pkg::ORD_LIMIT, 32'd0, 16'hFFFF, 24'hFF_FFFF);
        send_cancel(32'hFFFF_FFFF);
        send_cancel(32'hFFFF_FFFF);                   // already gone
        send_order(lobm_pkg::SIDE_BUY, lobm_pkg::ORD_LIMIT, 32'd14, 16'hFFFF, 24'd1);
        send_order(lobm_pkg::SIDE_SELL, lobm_pkg::ORD_MARKET, 32'd15, 16'hFFFF, 24'd100);
        send_cancel(32'd0);
        clear_book();
        wait_drained();
    endtask

    // Fill every entry, overflow once, then sweep the whole side.
    task automatic test_book_full();
        for (int i = 0; i < CAP; i++)
            send_order(lobm_pkg::SIDE_BUY, lobm_pkg::ORD_LIMIT, 32'(5000 + i),
                       16'(200 + (i % 3)), 24'd2);
        send_order(lobm_pkg::SIDE_BUY, lobm_pkg::ORD_LIMIT, 32'd9999, 16'd150, 24'd2);
        // Sweeps the higher bids and rests what is left.
        send_order(lobm_pkg::SIDE_SELL, lobm_pkg::ORD_LIMIT, 32'd9998, 16'd201, 24'd100);
        send_order(lobm_pkg::SIDE_SELL, lobm_pkg::ORD_MARKET, 32'd9997, 16'd0, 24'd500);
        wait_drained();
    endtask

    // Random requests: mostly crossing orders and cancels on a narrow price band.
    task automatic test_random(int count);
        lobm_pkg::req_t r;
        int live[$];
        for (int n = 0; n < count; n++)
        begin
            r.is_cancel = ($urandom_range(0, 99) < 20);
            r.id = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(1, 60)) : $urandom;
            if (r.is_cancel && $urandom_range(0, 3) != 0)
            begin
                live = {};
                for (int i = 0; i < CAP; i++)
                    if (bk_valid[i])
                        live = {live, i};
                if (live.size() > 0)
                    r.id = bk_id[live[$urandom_range(0, live.size() - 1)]];
            end
            r.sell = 1'($urandom);
            r.market = ($urandom_range(0, 99) < 15);
            r.price = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(1000, 1010));
            r.qty = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(1, 40));
            r.sym = 16'($urandom);
            r.ts = $urandom;
            send_item(r);
        end
    endtask

    // Hold the receiver off long enough that the request side backs up.
    task automatic test_backpressure();
        stall_request = 3000;
        sender_idles = 1'b0;
        test_random(12);
        sender_idles = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < CAP; i++)
        begin
            bk_valid[i] = 1'b0;
            bk_id[i] = '0;
            bk_sell[i] = 1'b0;
            bk_price[i] = '0;
            bk_qty[i] = '0;
            bk_arrival[i] = '0;
        end
        arrival_cnt = '0;
        mismatch_count = 0;
        cycle_count = 0;
        stall_request = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req_type <= lobm_pkg::REQ_ADD;
        req_id <= '0;
        side <= lobm_pkg::SIDE_BUY;
        order_type <= lobm_pkg::ORD_LIMIT;
        price <= '0;
        quantity <= '0;
        symbol_code <= '0;
        timestamp <= '0;
        res_ready <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_book_full();
        test_random(60);
        test_backpressure();
        // A stretch with no idling on either side.
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        test_random(40);
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        test_random(60);

        wait_drained();
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// ----- limit_order_book_matcher_core.f -----
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_front.sv
hw/rtl/lobm_queue.sv
hw/rtl/lobm_engine.sv
hw/rtl/limit_order_book_matcher_core.sv
hw/rtl/lobm_checker.sv
verif/tb.sv
